// ===== rtl/ipsp_pkg.sv =====
// Shared constants and types for the instruction-address stride prefetcher.
`timescale 1ns / 1ps
`default_nettype none

package ipsp_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DEF_TABLE_ENTRIES     = 256;
  localparam int DEF_PF_DEGREE         = 4;
  localparam int DEF_BLOCK_OFFSET_BITS = 6;

  // Stream and register port widths
  localparam int ADDR_W    = 64;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int THR_W      = 3;

  // Register map (word index = paddr[2])
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 3'd2;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ip_stride_prefetch_confidence_core.sv =====
// Instruction-address stride prefetcher with a per-entry confidence count.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Word contents (low bit up)
// s_*       in   s_tvalid/s_tready  tdata: access_addr[63:0], instr_addr[63:0]; tuser: light load
// m_*       out  m_tvalid/m_tready  tdata: prefetch_addr[63:0]; tuser: fill level; tlast: last
// apb       in   psel&penable       0x0: prefetch threshold[2:0]
//
// After rst the table is swept clear, one entry per cycle, with s_tready low meanwhile
// (register writes are still taken). Each access then takes a lookup step and, on a tag
// hit, an update step, as set by the one-port table read/modify/write; a hit that reaches
// the threshold then emits PF_DEGREE prefetch words, one per cycle while m_tready allows.
// A stalled m_tready holds the output register and the prefetch run; the next access
// is taken as soon as the last prefetch word of the run sits in the output register.

module ip_stride_prefetch_confidence_core
  import ipsp_pkg::*;
#(
  parameter int TABLE_ENTRIES     = DEF_TABLE_ENTRIES,     // power of two
  parameter int PF_DEGREE         = DEF_PF_DEGREE,
  parameter int BLOCK_OFFSET_BITS = DEF_BLOCK_OFFSET_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // access stream
  input  wire logic                    s_tvalid,
  output      logic                    s_tready,
  input  wire logic [2*ADDR_W-1:0]     s_tdata,   // access_addr, instr_addr
  input  wire logic                    s_tuser,   // mshr_light_load
  // prefetch stream
  output      logic                    m_tvalid,
  input  wire logic                    m_tready,
  output      logic [ADDR_W-1:0]       m_tdata,   // prefetch_addr
  output      logic                    m_tuser,   // fill_this_level
  output      logic                    m_tlast,   // last_of_run
  // register port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   paddr,
  input  wire logic [CFG_DATA_W-1:0]   pwdata,
  output      logic [CFG_DATA_W-1:0]   prdata,
  output      logic                    pready
);

  localparam int LOG2_ENT = $clog2(TABLE_ENTRIES);
  localparam int IDX_W    = (LOG2_ENT > 0) ? LOG2_ENT : 1;
  localparam int TAG_W    = ADDR_W - LOG2_ENT;
  localparam int LINE_W   = ADDR_W - BLOCK_OFFSET_BITS;
  localparam int DELTA_W  = LINE_W + 1;
  localparam int CNT_W    = $clog2(PF_DEGREE + 1);
  localparam int CMP_W    = (CNT_W > THR_W) ? CNT_W : THR_W;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [LINE_W-1:0]  line;
    logic               dvalid;
    logic [DELTA_W-1:0] delta;
    logic [CNT_W-1:0]   count;
  } entry_t;

  // ---------------------------------------------------------------- config
  logic [THR_W-1:0] threshold;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? CFG_DATA_W'(threshold) : '0;

  // ---------------------------------------------------------------- input split
  logic [ADDR_W-1:0] in_access;
  logic [ADDR_W-1:0] in_instr;
  logic [IDX_W-1:0]  in_idx;
  logic [TAG_W-1:0]  in_tag;
  logic [LINE_W-1:0] in_line;
  logic              s_accept;

  assign in_access = s_tdata[ADDR_W-1:0];
  assign in_instr  = s_tdata[2*ADDR_W-1:ADDR_W];
  assign in_idx    = (LOG2_ENT > 0) ? in_instr[IDX_W-1:0] : '0;
  assign in_tag    = TAG_W'(in_instr >> LOG2_ENT);
  assign in_line   = LINE_W'(in_access >> BLOCK_OFFSET_BITS);

  // ---------------------------------------------------------------- sequencer regs
  state_t            state, state_next;
  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W-1:0]  cur_idx;
  logic [TAG_W-1:0]  cur_tag;
  logic [LINE_W-1:0] cur_line;
  logic              cur_light;
  entry_t            rd_entry;
  logic [DELTA_W-1:0] diff;
  logic              hit;
  logic [LINE_W-1:0] pf_line;
  logic [CNT_W-1:0]  emit_cnt;

  // table write port
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  // update-stage logic
  logic              same_delta;
  logic [CNT_W-1:0]  count_next;
  logic              issue;
  logic              out_free;
  logic              emit_last;
  logic [LINE_W-1:0] pf_sum;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign emit_last = (emit_cnt == CNT_W'(PF_DEGREE - 1));
  assign pf_sum   = pf_line + diff[LINE_W-1:0];

  // tag match is looked at in the lookup cycle straight off the read data
  assign hit = rd_entry.valid && (rd_entry.tag == cur_tag);

  // repeat count: saturating rise on a repeated delta, else restart at one
  always_comb begin
    same_delta = rd_entry.dvalid && (diff == rd_entry.delta);
    if (same_delta) begin
      count_next = (rd_entry.count < CNT_W'(PF_DEGREE)) ? rd_entry.count + 1'b1
                                                        : rd_entry.count;
    end else begin
      count_next = CNT_W'(1);
    end
    issue = CMP_W'(count_next) >= CMP_W'(threshold);
  end

  // table write: clear sweep, replacement on a miss, update on a hit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
      end
      ST_LOOKUP: begin
        wr_en         = ~hit;
        wr_data.valid = 1'b1;
        wr_data.tag   = cur_tag;
        wr_data.line  = cur_line;
      end
      ST_UPDATE: begin
        wr_en          = 1'b1;
        wr_data.valid  = 1'b1;
        wr_data.tag    = cur_tag;
        wr_data.line   = cur_line;
        wr_data.dvalid = 1'b1;
        wr_data.delta  = diff;
        wr_data.count  = count_next;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == IDX_W'(TABLE_ENTRIES - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (s_accept) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = hit ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: state_next = issue ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (out_free && emit_last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- table memory
  entry_t table_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (s_accept) begin
      rd_entry <= table_mem[in_idx];
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (s_accept) begin
      cur_idx   <= in_idx;
      cur_tag   <= in_tag;
      cur_line  <= in_line;
      cur_light <= s_tuser;
    end
    if (state == ST_LOOKUP) begin
      diff <= {1'b0, cur_line} - {1'b0, rd_entry.line};
    end
    if (state == ST_UPDATE) begin
      pf_line  <= cur_line;
      emit_cnt <= '0;
    end
    if (state == ST_EMIT && out_free) begin
      pf_line  <= pf_sum;
      emit_cnt <= emit_cnt + 1'b1;
      m_tdata  <= {pf_sum, BLOCK_OFFSET_BITS'(0)};
      m_tuser  <= cur_light;
      m_tlast  <= emit_last;
    end
  end

endmodule

`default_nettype wire
